[hw/rtl/per_client_circuit_breaker_macros.svh]
// assertion macros used by the checker file
// no dependencies; every macro samples on clk and is disabled during rst
`ifndef PER_CLIENT_CIRCUIT_BREAKER_MACROS_SVH
`define PER_CLIENT_CIRCUIT_BREAKER_MACROS_SVH

// same-cycle implication
`define CB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cb_pkg.sv]
// shared types, codes and sizes of the per-client circuit breaker
// no dependencies
package cb_pkg;

  localparam int CLIENTS    = 16;
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 8;
  localparam int IDX_BITS   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int THR_BITS   = 8;
  localparam int COOL_BITS  = 16;
  localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

  localparam logic [1:0] FUNC_ALLOW   = 2'd0;
  localparam logic [1:0] FUNC_SUCCESS = 2'd1;
  localparam logic [1:0] FUNC_FAILURE = 2'd2;
  localparam logic [1:0] FUNC_TICK    = 2'd3;

  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_HALF   = 2'd2;

  localparam logic CFG_COOLDOWN  = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [1:0]            mode;
    logic                  probe;
    logic [COUNT_BITS-1:0] count;
    logic [TIME_BITS-1:0]  open_time;
  } entry_t;

  typedef struct packed {
    logic       opened_event;
    logic [1:0] breaker_state;
    logic       admitted;
  } result_t;

endpackage

[hw/rtl/cb_step.sv]
// next-entry and result logic for one item on one breaker entry
// depends on cb_pkg
module cb_step
  import cb_pkg::*;
(
  input  logic [1:0]           func,
  input  entry_t               cur,
  input  logic [TIME_BITS-1:0] time_now,
  input  logic [COOL_BITS-1:0] cooldown,
  input  logic [THR_BITS-1:0]  fail_limit,
  output entry_t               nxt,
  output result_t              res
);

  logic [TIME_BITS-1:0]  since;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  cool_done;
  logic                  thr_hit;

  assign since     = time_now - cur.open_time;
  assign cool_done = since >= TIME_BITS'(cooldown);
  assign count_inc = (&cur.count) ? cur.count : cur.count + 1'b1;
  assign thr_hit   = CMP_BITS'(count_inc) >= CMP_BITS'(fail_limit);

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (func)
      FUNC_ALLOW: begin
        if (cur.mode == MODE_CLOSED) begin
          res.admitted = 1'b1;
        end else if (cur.mode == MODE_OPEN) begin
          if (cool_done) begin
            nxt.mode     = MODE_HALF;
            nxt.probe    = 1'b1;
            res.admitted = 1'b1;
          end
        end else if (!cur.probe) begin
          nxt.probe    = 1'b1;
          res.admitted = 1'b1;
        end
      end
      FUNC_SUCCESS: begin
        nxt.count = '0;
        if (cur.mode == MODE_HALF) begin
          nxt.mode  = MODE_CLOSED;
          nxt.probe = 1'b0;
        end
      end
      FUNC_FAILURE: begin
        if (cur.mode == MODE_HALF) begin
          nxt.mode         = MODE_OPEN;
          nxt.open_time    = time_now;
          nxt.probe        = 1'b0;
          res.opened_event = 1'b1;
        end else begin
          nxt.count = count_inc;
          if (cur.mode == MODE_CLOSED && thr_hit) begin
            nxt.mode         = MODE_OPEN;
            nxt.open_time    = time_now;
            nxt.probe        = 1'b0;
            res.opened_event = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.breaker_state = nxt.mode;
  end

endmodule

[hw/rtl/per_client_circuit_breaker.sv]
// A table of circuit breakers, one per client index, held in flip-flops.
// Each item is taken into an input register; when the output register is free
// or being read, its entry is read, updated and written back while the result
// is loaded into the output register, so a result passes the input register and
// then the output register before it is offered; one item is taken every cycle
// as long as the output side keeps up. The rate is set by the single
// read-modify-write of the entry table, done combinationally and written back at
// the edge that loads the result, so that an item right behind another on the
// same client sees its update. Reset clears every entry to closed at once;
// configuration writes take effect on the next cycle.
// depends on cb_pkg and cb_step
module per_client_circuit_breaker
  import cb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [3:0] client_index, [7:4] zero
  input  logic [1:0]           s_tuser,   // [1:0] func
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [0] admitted, [2:1] breaker_state,
                                          // [3] opened_event, [7:4] zero
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [COOL_BITS-1:0] cfg_wdata
);

  logic                 in_valid;
  logic [1:0]           in_func;
  logic [3:0]           in_idx;
  logic [COOL_BITS-1:0] cooldown;
  logic [THR_BITS-1:0]  fail_limit;
  logic [TIME_BITS-1:0] time_now;
  entry_t               table_q [CLIENTS];
  logic                 advance;
  logic                 fire;
  logic                 idx_ok;
  logic [IDX_BITS-1:0]  entry_sel;
  entry_t               cur;
  entry_t               entry_next;
  result_t              step_res;
  result_t              res;
  result_t              res_next;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign fire      = in_valid && advance;
  assign idx_ok    = 9'(in_idx) < 9'(CLIENTS);
  assign entry_sel = IDX_BITS'(in_idx);
  assign cur       = table_q[entry_sel];
  assign res_next  = idx_ok ? step_res : '0;
  assign m_tdata   = {4'b0, res};

  cb_step u_step (
    .func       (in_func),
    .cur        (cur),
    .time_now   (time_now),
    .cooldown   (cooldown),
    .fail_limit (fail_limit),
    .nxt        (entry_next),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_idx  <= s_tdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown   <= COOL_BITS'(30);
      fail_limit <= THR_BITS'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COOLDOWN:  cooldown   <= cfg_wdata;
        CFG_THRESHOLD: fail_limit <= cfg_wdata[THR_BITS-1:0];
        default:       cooldown   <= cooldown;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (fire && in_func == FUNC_TICK) begin
      time_now <= time_now + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLIENTS; i++) begin
        table_q[i] <= '0;
      end
    end else if (fire && idx_ok) begin
      table_q[entry_sel] <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

[hw/rtl/cb_checker.sv]
// port-level checks of the per-client circuit breaker results
// depends on cb_pkg and the assertion macro header; bound to the top level
`include "per_client_circuit_breaker_macros.svh"

module cb_checker
  import cb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  `CB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `CB_ASSERT_IMPL(a_state_code, m_tvalid, m_tdata[2:1] != 2'd3, "invalid breaker state code")
  `CB_ASSERT_IMPL(a_open_event, m_tvalid && m_tdata[3], m_tdata[2:1] == MODE_OPEN && !m_tdata[0], "open event without open state")
  `CB_ASSERT_IMPL(a_admit_state, m_tvalid && m_tdata[0], m_tdata[2:1] != MODE_OPEN, "admitted while open")

endmodule

bind per_client_circuit_breaker cb_checker u_cb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[sim/per_client_circuit_breaker_tb.sv]
// self-checking testbench for the per-client circuit breaker table
// holds its own breaker table to predict every result; needs cb_pkg and the rtl
// directed items first, then random items under several cooldown and threshold settings
module per_client_circuit_breaker_tb import cb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]          func;
    logic [IDX_BITS-1:0] client;
  } req_t;

  localparam int CYCLE_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // [3:0] client_index, [7:4] zero
  logic [1:0]           s_tuser = '0;   // [1:0] func
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // [0] admitted, [2:1] breaker_state,
                                        // [3] opened_event, [7:4] zero
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_COOLDOWN;
  logic [COOL_BITS-1:0] cfg_wdata = '0;

  req_t    pending_reqs[$];
  result_t expected_results[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      mismatches = 0;
  int      cycles = 0;
  bit      in_taken = 1'b0;

  // predictor copy of the breaker table
  logic [COOL_BITS-1:0]  cooldown;
  logic [THR_BITS-1:0]   threshold;
  logic [TIME_BITS-1:0]  now_secs;
  logic [1:0]            mode_q [CLIENTS];
  logic                  probe_q [CLIENTS];
  logic [COUNT_BITS-1:0] fails_q [CLIENTS];
  logic [TIME_BITS-1:0]  trip_time [CLIENTS];

  per_client_circuit_breaker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void trip_breaker(logic [IDX_BITS-1:0] ci);
    mode_q[ci] = MODE_OPEN;
    trip_time[ci] = now_secs;
    probe_q[ci] = 1'b0;
  endfunction

  function automatic result_t breaker_next(req_t rq);
    result_t              r;
    logic [1:0]           m;
    logic [TIME_BITS-1:0] since;
    r = '0;
    if (rq.func == FUNC_TICK) now_secs = now_secs + 1'b1;
    m = mode_q[rq.client];
    case (rq.func)
      FUNC_ALLOW: begin
        if (m == MODE_CLOSED) begin
          r.admitted = 1'b1;
        end else if (m == MODE_OPEN) begin
          since = now_secs - trip_time[rq.client];
          if (since >= TIME_BITS'(cooldown)) begin
            mode_q[rq.client] = MODE_HALF;
            probe_q[rq.client] = 1'b1;
            r.admitted = 1'b1;
          end
        end else if (!probe_q[rq.client]) begin
          probe_q[rq.client] = 1'b1;
          r.admitted = 1'b1;
        end
      end
      FUNC_SUCCESS: begin
        fails_q[rq.client] = '0;
        if (m == MODE_HALF) begin
          mode_q[rq.client] = MODE_CLOSED;
          probe_q[rq.client] = 1'b0;
        end
      end
      FUNC_FAILURE: begin
        if (m == MODE_HALF) begin
          trip_breaker(rq.client);
          r.opened_event = 1'b1;
        end else begin
          // count saturates instead of wrapping
          if (fails_q[rq.client] != '1) fails_q[rq.client] = fails_q[rq.client] + 1'b1;
          if (m == MODE_CLOSED && CMP_BITS'(fails_q[rq.client]) >= CMP_BITS'(threshold)) begin
            trip_breaker(rq.client);
            r.opened_event = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.breaker_state = mode_q[rq.client];
    return r;
  endfunction

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(breaker_next('{func: s_tuser, client: s_tdata[IDX_BITS-1:0]}));
        in_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[3:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result item %h", m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.admitted !== want.admitted) begin
            $error("admitted: expected %0d, got %0d", want.admitted, got.admitted);
            mismatches++;
          end
          if (got.breaker_state !== want.breaker_state) begin
            $error("breaker_state: expected %0d, got %0d", want.breaker_state,
                   got.breaker_state);
            mismatches++;
          end
          if (got.opened_event !== want.opened_event) begin
            $error("opened_event: expected %0d, got %0d", want.opened_event,
                   got.opened_event);
            mismatches++;
          end
        end
      end
    end
  end

  // driver: new item only once the current one is taken
  always @(negedge clk) begin
    logic nv;
    req_t nr;
    nv = s_tvalid;
    nr = '{func: s_tuser, client: s_tdata[IDX_BITS-1:0]};
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || in_taken) begin
      nv = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nr = pending_reqs.pop_front();
        nv = 1'b1;
      end
    end
    in_taken = 1'b0;
    s_tvalid <= nv;
    s_tuser <= nr.func;
    s_tdata <= 8'(nr.client);
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic queue_req(logic [1:0] fn, int ci);
    pending_reqs.push_back('{func: fn, client: IDX_BITS'(ci)});
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(int cool, int thr);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_COOLDOWN;
    cfg_wdata <= COOL_BITS'(cool);
    cooldown = COOL_BITS'(cool);
    @(negedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= COOL_BITS'(thr);
    threshold = THR_BITS'(thr);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic req_t rand_req();
    req_t r;
    int   k;
    k = $urandom_range(99);
    if (k < 35) r.func = FUNC_ALLOW;
    else if (k < 52) r.func = FUNC_SUCCESS;
    else if (k < 80) r.func = FUNC_FAILURE;
    else r.func = FUNC_TICK;
    // mostly a few busy clients so breakers cycle through all states
    if ($urandom_range(3) != 0) r.client = IDX_BITS'($urandom_range(3));
    else r.client = IDX_BITS'($urandom_range(CLIENTS - 1));
    return r;
  endfunction

  task automatic run_phase(int cool, int thr, int sidle, int rstall, int n);
    write_limits(cool, thr);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) pending_reqs.push_back(rand_req());
    drain();
  endtask

  initial begin
    cooldown = 16'd30;
    threshold = 8'd5;
    now_secs = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      mode_q[i] = MODE_CLOSED;
      probe_q[i] = 1'b0;
      fails_q[i] = '0;
      trip_time[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limits: five failures open the breaker
    queue_req(FUNC_ALLOW, 3);
    repeat (5) queue_req(FUNC_FAILURE, 3);

    // threshold one, cooldown two: full open, half-open, close, reopen cycle
    write_limits(2, 1);
    queue_req(FUNC_ALLOW, 0);
    queue_req(FUNC_SUCCESS, 15);
    queue_req(FUNC_FAILURE, 0);
    queue_req(FUNC_ALLOW, 0);
    queue_req(FUNC_FAILURE, 0);
    queue_req(FUNC_SUCCESS, 0);
    queue_req(FUNC_TICK, 0);
    queue_req(FUNC_TICK, 15);
    queue_req(FUNC_ALLOW, 0);
    queue_req(FUNC_ALLOW, 0);
    queue_req(FUNC_SUCCESS, 0);
    queue_req(FUNC_FAILURE, 0);
    queue_req(FUNC_TICK, 10);
    queue_req(FUNC_TICK, 5);
    queue_req(FUNC_ALLOW, 0);
    queue_req(FUNC_FAILURE, 0);

    // zero threshold and zero cooldown
    write_limits(0, 0);
    queue_req(FUNC_FAILURE, 5);
    queue_req(FUNC_ALLOW, 5);
    queue_req(FUNC_ALLOW, 5);
    queue_req(FUNC_SUCCESS, 5);

    run_phase(3, 2, 0, 0, 100);
    run_phase(0, 0, 51, 0, 100);
    run_phase(1, 1, 0, 51, 100);
    run_phase(65535, 255, 24, 24, 100);
    run_phase(30, 5, 24, 24, 100);
    run_phase(2, 4, 0, 0, 100);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[per_client_circuit_breaker.f]
+incdir+hw/rtl
hw/rtl/cb_pkg.sv
hw/rtl/cb_step.sv
hw/rtl/per_client_circuit_breaker.sv
hw/rtl/cb_checker.sv
sim/per_client_circuit_breaker_tb.sv
